@@ rtl/core/abm_pkg.sv @@
// Shared types and operation codes for the adjacency bit matrix.
`default_nettype none
package abm_pkg;

	typedef enum logic [2:0] {
		OP_INSERT = 3'd0,
		OP_REMOVE = 3'd1,
		OP_QUERY  = 3'd2,
		OP_ADD    = 3'd3,
		OP_NEXT   = 3'd4
	} op_t;

	// controller -> datapath
	typedef struct packed {
		logic capture;
		logic exec;
		logic mirror;
		logic search;
	} abm_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic go_mirror;
		logic go_search;
	} abm_status_t;

endpackage
`default_nettype wire

@@ rtl/core/abm_ctrl.sv @@
// Sequencing state machine for the adjacency bit matrix.
`default_nettype none
module abm_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  abm_pkg::abm_status_t  status,
	output logic                  busy,
	output abm_pkg::abm_cmd_t     cmd
);
	import abm_pkg::*;

	typedef enum logic [3:0] {
		ST_IDLE   = 4'b0001,
		ST_EXEC   = 4'b0010,
		ST_MIRROR = 4'b0100,
		ST_SEARCH = 4'b1000
	} state_t;

	state_t state_q, state_d;

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (start) state_d = ST_EXEC;
			end
			ST_EXEC: begin
				if (status.go_mirror) state_d = ST_MIRROR;
				else if (status.go_search) state_d = ST_SEARCH;
				else state_d = ST_IDLE;
			end
			ST_MIRROR: state_d = ST_IDLE;
			ST_SEARCH: state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else state_q <= state_d;
	end

	assign busy        = (state_q != ST_IDLE);
	assign cmd.capture = (state_q == ST_IDLE) && start;
	assign cmd.exec    = (state_q == ST_EXEC);
	assign cmd.mirror  = (state_q == ST_MIRROR);
	assign cmd.search  = (state_q == ST_SEARCH);

endmodule
`default_nettype wire

@@ rtl/core/abm_datapath.sv @@
// Row memory, counters, search tree and result registers of the adjacency bit matrix.
`default_nettype none
module abm_datapath #(
	parameter int MAX_VERTICES = 64
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  abm_pkg::abm_cmd_t     cmd,
	output abm_pkg::abm_status_t  status,
	input  logic                  cfg_write,
	input  logic                  cfg_data,
	input  logic [2:0]            operation,
	input  logic [5:0]            source_vertex,
	input  logic [5:0]            target_vertex,
	input  logic [6:0]            search_start,
	output logic                  done,
	output logic                  edge_present,
	output logic                  neighbor_found,
	output logic [5:0]            neighbor_index,
	output logic [6:0]            vertex_total,
	output logic [12:0]           edge_total,
	output logic                  error_flag
);
	import abm_pkg::*;

	localparam int AW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
	localparam int VW = $clog2(MAX_VERTICES + 1);
	localparam int CW = (VW > 7) ? VW : 7;
	localparam int NG = (MAX_VERTICES + 7) / 8;
	localparam int IW = (AW + 3 > 6) ? AW + 3 : 6;

	// row memory; a row never written reads as zero through its valid flag
	logic [MAX_VERTICES-1:0] mem [MAX_VERTICES];
	logic [MAX_VERTICES-1:0] row_vld_q;
	logic [MAX_VERTICES-1:0] rd_src_q, rd_dst_q;
	logic                    vld_src_q, vld_dst_q;

	logic        directed_q;
	logic [2:0]  op_q;
	logic [5:0]  src_q, dst_q;
	logic [6:0]  start_q;
	logic [VW-1:0] vcount_q, vcount_d;
	logic [12:0] ecount_q, ecount_d;

	logic [MAX_VERTICES-1:0] row_src, row_dst, wr_data;
	logic          src_ok, dst_ok, present;
	logic          err, pres_res, fwd_we, search_ok;
	logic          wr_en, wr_val;
	logic [AW-1:0] wr_addr, wr_bit;

	logic [NG*8-1:0] row_pad, hit;
	logic [NG-1:0]   any_d, any_s1;
	logic [2:0]      pos_d [NG];
	logic [2:0]      pos_s1 [NG];
	logic            found;
	logic [IW-1:0]   idx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) directed_q <= 1'b0;
		else if (cfg_write) directed_q <= cfg_data;
	end

	// transaction capture and row reads at accept
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			op_q      <= operation;
			src_q     <= source_vertex;
			dst_q     <= target_vertex;
			start_q   <= search_start;
			rd_src_q  <= mem[AW'(source_vertex)];
			rd_dst_q  <= mem[AW'(target_vertex)];
			vld_src_q <= row_vld_q[AW'(source_vertex)];
			vld_dst_q <= row_vld_q[AW'(target_vertex)];
		end
	end

	assign row_src = vld_src_q ? rd_src_q : '0;
	assign row_dst = vld_dst_q ? rd_dst_q : '0;
	assign src_ok  = CW'(src_q) < CW'(vcount_q);
	assign dst_ok  = CW'(dst_q) < CW'(vcount_q);
	assign present = row_src[AW'(dst_q)];

	always_comb begin
		err       = 1'b0;
		pres_res  = 1'b0;
		fwd_we    = 1'b0;
		search_ok = 1'b0;
		ecount_d  = ecount_q;
		vcount_d  = vcount_q;
		case (op_q)
			OP_INSERT: begin
				if (src_ok && dst_ok) begin
					pres_res = present;
					fwd_we   = 1'b1;
					if (!present) ecount_d = ecount_q + 13'd1;
				end else begin
					err = 1'b1;
				end
			end
			OP_REMOVE: begin
				if (src_ok && dst_ok) begin
					pres_res = present;
					fwd_we   = 1'b1;
					if (present) ecount_d = ecount_q - 13'd1;
				end else begin
					err = 1'b1;
				end
			end
			OP_QUERY: begin
				if (src_ok && dst_ok) pres_res = present;
				else err = 1'b1;
			end
			OP_ADD: begin
				if (vcount_q == VW'(MAX_VERTICES)) err = 1'b1;
				else vcount_d = vcount_q + VW'(1);
			end
			OP_NEXT: begin
				if (src_ok) search_ok = 1'b1;
				else err = 1'b1;
			end
			default: err = 1'b1;
		endcase
	end

	assign status.go_mirror = fwd_we && !directed_q;
	assign status.go_search = search_ok;

	// single write port: forward bit in exec, mirrored bit in mirror, the cycle after
	assign wr_val  = (op_q == OP_INSERT);
	assign wr_en   = (cmd.exec && fwd_we) || cmd.mirror;
	assign wr_addr = cmd.mirror ? AW'(dst_q) : AW'(src_q);
	assign wr_bit  = cmd.mirror ? AW'(src_q) : AW'(dst_q);

	always_comb begin
		wr_data         = cmd.mirror ? row_dst : row_src;
		wr_data[wr_bit] = wr_val;
	end

	always_ff @(posedge clk) begin
		if (wr_en) mem[wr_addr] <= wr_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) row_vld_q <= '0;
		else if (wr_en) row_vld_q[wr_addr] <= 1'b1;
	end

	// search, first level: window mask and first hit within each byte
	assign row_pad = (NG*8)'(row_src);

	always_comb begin
		for (int c = 0; c < NG*8; c++) begin
			hit[c] = row_pad[c] && (c >= int'(start_q)) && (c < int'(vcount_q));
		end
		for (int g = 0; g < NG; g++) begin
			any_d[g] = |hit[g*8 +: 8];
			pos_d[g] = 3'd0;
			for (int k = 7; k >= 0; k--) begin
				if (hit[g*8 + k]) pos_d[g] = 3'(k);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			any_s1 <= any_d;
			pos_s1 <= pos_d;
		end
	end

	// search, second level: first byte with a hit
	always_comb begin
		found = |any_s1;
		idx   = '0;
		for (int g = NG - 1; g >= 0; g--) begin
			if (any_s1[g]) idx = IW'(g * 8) + IW'(pos_s1[g]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vcount_q <= '0;
			ecount_q <= '0;
		end else if (cmd.exec) begin
			vcount_q <= vcount_d;
			ecount_q <= ecount_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done           <= 1'b0;
			edge_present   <= 1'b0;
			neighbor_found <= 1'b0;
			neighbor_index <= '0;
			vertex_total   <= '0;
			edge_total     <= '0;
			error_flag     <= 1'b0;
		end else if (cmd.exec && !search_ok) begin
			done           <= 1'b1;
			edge_present   <= pres_res;
			neighbor_found <= 1'b0;
			neighbor_index <= '0;
			vertex_total   <= 7'(vcount_d);
			edge_total     <= ecount_d;
			error_flag     <= err;
		end else if (cmd.search) begin
			done           <= 1'b1;
			edge_present   <= 1'b0;
			neighbor_found <= found;
			neighbor_index <= idx[5:0];
			vertex_total   <= 7'(vcount_q);
			edge_total     <= ecount_q;
			error_flag     <= 1'b0;
		end else begin
			done <= 1'b0;
		end
	end

endmodule
`default_nettype wire

@@ rtl/core/adjacency_bit_matrix.sv @@
// Top level of the adjacency bit matrix: controller and datapath.
//
//  channel  | handshake             | payload
//  ---------+-----------------------+---------------------------------------------------
//  command  | start / busy          | operation, source_vertex, target_vertex, search_start
//  result   | done (one cycle)      | edge_present, neighbor_found, neighbor_index,
//           |                       | vertex_total, edge_total, error_flag
//  config   | cfg_write             | cfg_data (directed)
//
// Query, add vertex, directed insert/remove and rejected transactions run exec only;
// undirected insert/remove add mirror (second write of the single memory write port),
// next neighbor adds search (two-level registered search over the row).
// done is registered at the end of exec, or at the end of search for next neighbor.
// Reset clears the matrix at once through per-row valid flags; no clearing pass.
// The receiver cannot stall; results must be taken in the done cycle.
`default_nettype none
module adjacency_bit_matrix #(
	parameter int MAX_VERTICES = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic        cfg_write,
	input  logic        cfg_data,
	input  logic [2:0]  operation,
	input  logic [5:0]  source_vertex,
	input  logic [5:0]  target_vertex,
	input  logic [6:0]  search_start,
	output logic        done,
	output logic        edge_present,
	output logic        neighbor_found,
	output logic [5:0]  neighbor_index,
	output logic [6:0]  vertex_total,
	output logic [12:0] edge_total,
	output logic        error_flag
);
	import abm_pkg::*;

	abm_cmd_t    cmd;
	abm_status_t status;

	abm_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.status (status),
		.busy   (busy),
		.cmd    (cmd)
	);

	abm_datapath #(
		.MAX_VERTICES (MAX_VERTICES)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.status         (status),
		.cfg_write      (cfg_write),
		.cfg_data       (cfg_data),
		.operation      (operation),
		.source_vertex  (source_vertex),
		.target_vertex  (target_vertex),
		.search_start   (search_start),
		.done           (done),
		.edge_present   (edge_present),
		.neighbor_found (neighbor_found),
		.neighbor_index (neighbor_index),
		.vertex_total   (vertex_total),
		.edge_total     (edge_total),
		.error_flag     (error_flag)
	);

endmodule
`default_nettype wire

@@ rtl/core/abm_checker.sv @@
// Port-level checks for the adjacency bit matrix, bound to the top level.
`default_nettype none
module abm_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        start,
	input logic        busy,
	input logic        done,
	input logic        error_flag,
	input logic [6:0]  vertex_total,
	input logic [12:0] edge_total
);

	// an accepted transaction raises busy
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("busy low right after accepted transaction");

	a_no_early_done: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> !done)
		else $error("result one cycle after accept");

	// totals move only with a result
	a_totals_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!done |-> $stable(vertex_total) && $stable(edge_total))
		else $error("totals changed without a result");

	// a rejected transaction changes no count
	a_error_no_change: assert property (@(posedge clk) disable iff (!arst_n)
		done && error_flag |-> vertex_total == $past(vertex_total)
			&& edge_total == $past(edge_total))
		else $error("rejected transaction changed a count");

endmodule

bind adjacency_bit_matrix abm_checker u_abm_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.start        (start),
	.busy         (busy),
	.done         (done),
	.error_flag   (error_flag),
	.vertex_total (vertex_total),
	.edge_total   (edge_total)
);
`default_nettype wire

@@ dv/tb_top.sv @@
// Self-checking testbench for the adjacency bit matrix: directed table, then random traffic.
`default_nettype none
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import abm_pkg::*;

	localparam int MAX_VERTICES = 64;
	localparam int PHASES = 6;
	localparam int PHASE_ITEMS = 155;
	localparam int DIR_ROWS = 26;
	localparam logic [2:0] OP_ILLEGAL_LO  = 3'd5;
	localparam logic [2:0] OP_ILLEGAL_MID = 3'd6;
	localparam logic [2:0] OP_ILLEGAL_HI  = 3'd7;
	localparam bit MODE_UNDIRECTED = 1'b0;
	localparam bit MODE_DIRECTED   = 1'b1;

	typedef struct packed {
		logic        present;
		logic        found;
		logic [5:0]  nbr;
		logic [6:0]  vtot;
		logic [12:0] etot;
		logic        err;
	} graph_res_t;

	typedef struct packed {
		bit         is_cfg;
		bit         mode;
		logic [2:0] op;
		logic [5:0] src;
		logic [5:0] dst;
		logic [6:0] sst;
		bit         typed;
		graph_res_t want;
	} stim_row_t;

	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	logic        cfg_write;
	logic        cfg_data;
	logic [2:0]  operation;
	logic [5:0]  source_vertex;
	logic [5:0]  target_vertex;
	logic [6:0]  search_start;
	logic        done;
	logic        edge_present;
	logic        neighbor_found;
	logic [5:0]  neighbor_index;
	logic [6:0]  vertex_total;
	logic [12:0] edge_total;
	logic        error_flag;

	adjacency_bit_matrix #(.MAX_VERTICES(MAX_VERTICES)) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.cfg_write(cfg_write),
		.cfg_data(cfg_data),
		.operation(operation),
		.source_vertex(source_vertex),
		.target_vertex(target_vertex),
		.search_start(search_start),
		.done(done),
		.edge_present(edge_present),
		.neighbor_found(neighbor_found),
		.neighbor_index(neighbor_index),
		.vertex_total(vertex_total),
		.edge_total(edge_total),
		.error_flag(error_flag)
	);

	// shadow copy of the graph
	bit [MAX_VERTICES-1:0] adj_rows [MAX_VERTICES];
	int unsigned vcount;
	bit [12:0] ecount;
	bit is_directed;

	graph_res_t pending_results [$];
	int errors;
	stim_row_t dir_rows [DIR_ROWS];

	initial clk = 1'b0;
	always #2 clk = ~clk;

	function automatic graph_res_t apply_graph_op(logic [2:0] op, logic [5:0] s, logic [5:0] d,
			logic [6:0] st);
		graph_res_t r;
		bit hit;
		r = '0;
		case (op)
			OP_INSERT, OP_REMOVE, OP_QUERY: begin
				if (s >= vcount || d >= vcount) begin
					r.err = 1'b1;
				end else begin
					hit = adj_rows[s][d];
					r.present = hit;
					if (op == OP_INSERT) begin
						if (!hit) ecount = ecount + 13'd1;
						adj_rows[s][d] = 1'b1;
						if (!is_directed) adj_rows[d][s] = 1'b1;
					end else if (op == OP_REMOVE) begin
						if (hit) ecount = ecount - 13'd1;
						adj_rows[s][d] = 1'b0;
						if (!is_directed) adj_rows[d][s] = 1'b0;
					end
				end
			end
			OP_ADD: begin
				if (vcount >= MAX_VERTICES) r.err = 1'b1;
				else vcount++;
			end
			OP_NEXT: begin
				if (s >= vcount) begin
					r.err = 1'b1;
				end else begin
					for (int c = st; c < vcount && !r.found; c++) begin
						if (adj_rows[s][c]) begin
							r.found = 1'b1;
							r.nbr = c[5:0];
						end
					end
				end
			end
			default: r.err = 1'b1;
		endcase
		r.vtot = vcount[6:0];
		r.etot = ecount;
		return r;
	endfunction

	function automatic int pick_gap();
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 60) return 0;
		if (roll < 92) return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// caller sits at a falling edge; returns at the falling edge after acceptance
	task automatic send_cmd(logic [2:0] op, logic [5:0] s, logic [5:0] d, logic [6:0] st,
			bit typed, graph_res_t want);
		graph_res_t pred;
		start <= 1'b1;
		operation <= op;
		source_vertex <= s;
		target_vertex <= d;
		search_start <= st;
		do @(posedge clk); while (busy);
		pred = apply_graph_op(op, s, d, st);
		pending_results.insert(pending_results.size(), typed ? want : pred);
		@(negedge clk);
	endtask

	task automatic drain_results();
		start <= 1'b0;
		while (pending_results.size() != 0) @(negedge clk);
	endtask

	task automatic write_mode(bit mode);
		drain_results();
		repeat (4) @(negedge clk);
		cfg_write <= 1'b1;
		cfg_data <= mode;
		@(negedge clk);
		cfg_write <= 1'b0;
		is_directed = mode;
	endtask

	task automatic check_field(string name, int unsigned want, int unsigned got);
		if (want != got) begin
			$display("%0t ns: %s expected %0d got %0d", $time, name, want, got);
			errors++;
		end
	endtask

	always @(posedge clk) begin
		graph_res_t want;
		if (arst_n && done) begin
			if (pending_results.size() == 0) begin
				$display("%0t ns: result with no transaction pending", $time);
				errors++;
			end else begin
				want = pending_results.pop_front();
				check_field("edge_present", want.present, edge_present);
				check_field("neighbor_found", want.found, neighbor_found);
				check_field("neighbor_index", want.nbr, neighbor_index);
				check_field("vertex_total", want.vtot, vertex_total);
				check_field("edge_total", want.etot, edge_total);
				check_field("error_flag", want.err, error_flag);
			end
		end
	end

	initial begin
		#2_000_000;
		$display("end of test: mismatches");
		$finish;
	end

	initial begin
		logic [2:0] op;
		logic [5:0] s;
		logic [5:0] d;
		logic [6:0] st;
		int roll;
		int gap;
		bit no_idle;

		arst_n = 1'b0;
		start = 1'b0;
		cfg_write = 1'b0;
		cfg_data = 1'b0;
		operation = OP_QUERY;
		source_vertex = '0;
		target_vertex = '0;
		search_start = '0;
		errors = 0;
		vcount = 0;
		ecount = '0;
		is_directed = MODE_UNDIRECTED;
		foreach (adj_rows[i]) adj_rows[i] = '0;

		// cfg, mode, op, src, dst, start, typed, expected
		dir_rows = '{
			'{0, 0, OP_QUERY, 6'd0, 6'd0, 7'd0, 1, '{0, 0, 6'd0, 7'd0, 13'd0, 1}},
			'{0, 0, OP_NEXT, 6'd0, 6'd0, 7'd0, 1, '{0, 0, 6'd0, 7'd0, 13'd0, 1}},
			'{0, 0, OP_ILLEGAL_LO, 6'd0, 6'd0, 7'd0, 1, '{0, 0, 6'd0, 7'd0, 13'd0, 1}},
			'{0, 0, OP_ILLEGAL_HI, 6'd63, 6'd63, 7'd127, 1, '{0, 0, 6'd0, 7'd0, 13'd0, 1}},
			'{0, 0, OP_ILLEGAL_MID, 6'd5, 6'd9, 7'd3, 0, '0},
			'{0, 0, OP_ADD, 6'd0, 6'd0, 7'd0, 1, '{0, 0, 6'd0, 7'd1, 13'd0, 0}},
			'{0, 0, OP_ADD, 6'd0, 6'd0, 7'd0, 1, '{0, 0, 6'd0, 7'd2, 13'd0, 0}},
			'{0, 0, OP_ADD, 6'd0, 6'd0, 7'd0, 1, '{0, 0, 6'd0, 7'd3, 13'd0, 0}},
			'{0, 0, OP_INSERT, 6'd0, 6'd1, 7'd0, 1, '{0, 0, 6'd0, 7'd3, 13'd1, 0}},
			'{0, 0, OP_INSERT, 6'd0, 6'd1, 7'd0, 1, '{1, 0, 6'd0, 7'd3, 13'd1, 0}},
			'{0, 0, OP_QUERY, 6'd1, 6'd0, 7'd0, 0, '0},
			'{0, 0, OP_NEXT, 6'd1, 6'd0, 7'd0, 0, '0},
			'{0, 0, OP_NEXT, 6'd1, 6'd0, 7'd1, 0, '0},
			// start past the last vertex: no hit, no error
			'{0, 0, OP_NEXT, 6'd0, 6'd0, 7'd64, 1, '{0, 0, 6'd0, 7'd3, 13'd1, 0}},
			'{0, 0, OP_INSERT, 6'd0, 6'd3, 7'd0, 1, '{0, 0, 6'd0, 7'd3, 13'd1, 1}},
			'{0, 0, OP_REMOVE, 6'd63, 6'd0, 7'd0, 1, '{0, 0, 6'd0, 7'd3, 13'd1, 1}},
			'{0, 0, OP_INSERT, 6'd2, 6'd2, 7'd0, 0, '0},
			'{1, MODE_DIRECTED, OP_QUERY, 6'd0, 6'd0, 7'd0, 0, '0},
			'{0, 0, OP_REMOVE, 6'd0, 6'd1, 7'd0, 0, '0},
			// mirrored bit removed on its own; the next removal takes the counter under zero
			'{0, 0, OP_REMOVE, 6'd1, 6'd0, 7'd0, 0, '0},
			'{0, 0, OP_REMOVE, 6'd2, 6'd2, 7'd0, 0, '0},
			'{0, 0, OP_INSERT, 6'd1, 6'd2, 7'd0, 0, '0},
			'{0, 0, OP_QUERY, 6'd2, 6'd1, 7'd0, 0, '0},
			'{1, MODE_UNDIRECTED, OP_QUERY, 6'd0, 6'd0, 7'd0, 0, '0},
			'{0, 0, OP_NEXT, 6'd2, 6'd0, 7'd127, 0, '0},
			'{0, 0, OP_QUERY, 6'd63, 6'd63, 7'd0, 0, '0}
		};

		repeat (8) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (dir_rows[i]) begin
			if (dir_rows[i].is_cfg) begin
				write_mode(dir_rows[i].mode);
			end else begin
				send_cmd(dir_rows[i].op, dir_rows[i].src, dir_rows[i].dst, dir_rows[i].sst,
					dir_rows[i].typed, dir_rows[i].want);
				gap = pick_gap();
				if (gap != 0) begin
					start <= 1'b0;
					repeat (gap) @(negedge clk);
				end
			end
		end

		for (int ph = 0; ph < PHASES; ph++) begin
			write_mode(ph[0] ? MODE_UNDIRECTED : MODE_DIRECTED);
			no_idle = ($urandom_range(0, 3) == 0);
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				roll = $urandom_range(0, 99);
				if (roll < 10) op = OP_ADD;
				else if (roll < 40) op = OP_INSERT;
				else if (roll < 55) op = OP_REMOVE;
				else if (roll < 75) op = OP_QUERY;
				else if (roll < 97) op = OP_NEXT;
				else op = 3'($urandom_range(OP_ILLEGAL_LO, OP_ILLEGAL_HI));
				// mostly in-range endpoints once vertices exist
				if (vcount != 0 && $urandom_range(0, 99) < 85) begin
					s = 6'($urandom_range(0, vcount - 1));
					d = 6'($urandom_range(0, vcount - 1));
				end else begin
					s = 6'($urandom_range(0, 63));
					d = 6'($urandom_range(0, 63));
				end
				if ($urandom_range(0, 9) == 0) st = 7'($urandom_range(0, 127));
				else st = 7'($urandom_range(0, vcount));
				send_cmd(op, s, d, st, 1'b0, '0);
				if ($urandom_range(0, 99) == 0) begin
					drain_results();
				end else begin
					gap = no_idle ? 0 : pick_gap();
					if (gap != 0) begin
						start <= 1'b0;
						repeat (gap) @(negedge clk);
					end
				end
			end
		end

		drain_results();
		repeat (8) @(posedge clk);
		if (errors == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

endmodule
`default_nettype wire
